// File: src/msp_pkg.sv
package msp_pkg;

    localparam logic [2:0] KIND_IGNORE   = 3'd0;
    localparam logic [2:0] KIND_REALTIME = 3'd1;
    localparam logic [2:0] KIND_SX_START = 3'd2;
    localparam logic [2:0] KIND_SX_END   = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;
    localparam logic [2:0] KIND_DATA     = 3'd5;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_REALTIME = 3'd1;
    localparam logic [2:0] EV_CHANNEL  = 3'd2;
    localparam logic [2:0] EV_PARAM    = 3'd3;
    localparam logic [2:0] EV_APPLIED  = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    localparam logic [1:0] REG_ID_FIRST   = 2'd0;
    localparam logic [1:0] REG_ID_SECOND  = 2'd1;
    localparam logic [1:0] REG_ID_THIRD   = 2'd2;
    localparam logic [1:0] REG_AUTO_STORE = 2'd3;

    localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
    localparam logic [7:0] BYTE_START    = 8'hFA;
    localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
    localparam logic [7:0] BYTE_STOP     = 8'hFC;
    localparam logic [7:0] BYTE_SX_START = 8'hF0;
    localparam logic [7:0] BYTE_SX_END   = 8'hF7;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_BEND      = 4'hE;

    localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [6:0] CC_DATA_MSB   = 7'd6;
    localparam logic [6:0] CC_DATA_LSB   = 7'd38;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rx_byte;
    } entry_t;

    typedef struct packed {
        logic [6:0] id_first;
        logic [6:0] id_second;
        logic [6:0] id_third;
        logic       auto_store;
    } cfg_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] status_out;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [6:0] param_high;
        logic [6:0] param_low;
        logic [6:0] value_high;
        logic [6:0] value_low;
        logic       save_patch;
    } result_t;

endpackage

// File: src/msp_front.sv
module msp_front (
    input  logic [7:0]      rx_byte,
    output msp_pkg::entry_t entry
);

    always_comb begin
        entry.rx_byte = rx_byte;
        if (rx_byte[7:4] == msp_pkg::NIB_SYSTEM) begin
            if (rx_byte == msp_pkg::BYTE_CLOCK || rx_byte == msp_pkg::BYTE_START ||
                rx_byte == msp_pkg::BYTE_CONTINUE || rx_byte == msp_pkg::BYTE_STOP) begin
                entry.kind = msp_pkg::KIND_REALTIME;
            end else if (rx_byte == msp_pkg::BYTE_SX_START) begin
                entry.kind = msp_pkg::KIND_SX_START;
            end else if (rx_byte == msp_pkg::BYTE_SX_END) begin
                entry.kind = msp_pkg::KIND_SX_END;
            end else begin
                entry.kind = msp_pkg::KIND_IGNORE;
            end
        end else if (rx_byte[7]) begin
            entry.kind = msp_pkg::KIND_STATUS;
        end else begin
            entry.kind = msp_pkg::KIND_DATA;
        end
    end

endmodule

// File: src/msp_queue.sv
module msp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  msp_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output msp_pkg::entry_t head_entry
);

    msp_pkg::entry_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/msp_back.sv
module msp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  msp_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  msp_pkg::entry_t  head_entry,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output msp_pkg::result_t res
);

    localparam logic [3:0] PH_NONE   = 4'd0;
    localparam logic [3:0] PH_IGNORE = 4'd1;
    localparam logic [3:0] PH_ID0    = 4'd2;
    localparam logic [3:0] PH_ID1    = 4'd3;
    localparam logic [3:0] PH_ID2    = 4'd4;
    localparam logic [3:0] PH_PARAMH = 4'd5;
    localparam logic [3:0] PH_PARAML = 4'd6;
    localparam logic [3:0] PH_VALUEH = 4'd7;
    localparam logic [3:0] PH_VALUEL = 4'd8;

    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       rstat_reg, rstat_next;
    logic             need_two_reg, need_two_next;
    logic             rcount_reg, rcount_next;
    logic [6:0]       d0_reg, d0_next;
    logic [6:0]       d1_reg, d1_next;
    logic [6:0]       pph_reg, pph_next;
    logic [6:0]       ppl_reg, ppl_next;
    logic [6:0]       pvh_reg, pvh_next;
    logic             valid_reg, valid_next;
    msp_pkg::result_t res_reg, res_next;

    assign pop       = head_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb begin
        logic [7:0] ch;
        logic [6:0] dat;
        logic [6:0] c0;
        logic [6:0] c1;
        logic [3:0] kind;
        ch   = head_entry.rx_byte;
        dat  = ch[6:0];
        kind = rstat_reg[7:4];
        c0   = rcount_reg ? d0_reg : dat;
        c1   = rcount_reg ? dat : d1_reg;

        phase_next    = phase_reg;
        rstat_next    = rstat_reg;
        need_two_next = need_two_reg;
        rcount_next   = rcount_reg;
        d0_next       = d0_reg;
        d1_next       = d1_reg;
        pph_next      = pph_reg;
        ppl_next      = ppl_reg;
        pvh_next      = pvh_reg;
        valid_next    = valid_reg && !res_ready;
        res_next      = res_reg;

        if (pop) begin
            valid_next = 1'b1;
            res_next   = '0;
            unique case (head_entry.kind)
                msp_pkg::KIND_REALTIME: begin
                    res_next.event_res  = msp_pkg::EV_REALTIME;
                    res_next.status_out = ch;
                end
                msp_pkg::KIND_SX_START: begin
                    phase_next = PH_ID0;
                end
                msp_pkg::KIND_SX_END: begin
                    if (phase_reg == PH_PARAMH) begin
                        res_next.event_res  = msp_pkg::EV_APPLIED;
                        res_next.save_patch = cfg.auto_store;
                    end else if (phase_reg >= PH_ID0 && phase_reg <= PH_VALUEL) begin
                        res_next.event_res = msp_pkg::EV_ERROR;
                    end
                    phase_next = PH_NONE;
                end
                msp_pkg::KIND_STATUS: begin
                    phase_next    = PH_NONE;
                    rcount_next   = 1'b0;
                    rstat_next    = ch;
                    need_two_next = !(ch[7:4] == msp_pkg::NIB_POLY_AT ||
                                      ch[7:4] == msp_pkg::NIB_PROGRAM ||
                                      ch[7:4] == msp_pkg::NIB_CHAN_AT);
                end
                msp_pkg::KIND_DATA: begin
                    unique case (phase_reg)
                        PH_ID0: phase_next = (dat == cfg.id_first) ? PH_ID1 : PH_IGNORE;
                        PH_ID1: phase_next = (dat == cfg.id_second) ? PH_ID2 : PH_IGNORE;
                        PH_ID2: phase_next = (dat == cfg.id_third) ? PH_PARAMH : PH_IGNORE;
                        PH_PARAMH: begin
                            pph_next   = dat;
                            phase_next = PH_PARAML;
                        end
                        PH_PARAML: begin
                            ppl_next   = dat;
                            phase_next = PH_VALUEH;
                        end
                        PH_VALUEH: begin
                            pvh_next   = dat;
                            phase_next = PH_VALUEL;
                        end
                        PH_VALUEL: begin
                            res_next.event_res  = msp_pkg::EV_PARAM;
                            res_next.param_high = pph_reg;
                            res_next.param_low  = ppl_reg;
                            res_next.value_high = pvh_reg;
                            res_next.value_low  = dat;
                            phase_next          = PH_PARAMH;
                        end
                        PH_NONE: begin
                            if (rstat_reg != 8'd0) begin
                                d0_next     = c0;
                                d1_next     = c1;
                                rcount_next = !rcount_reg;
                                if (rcount_reg || !need_two_reg) begin
                                    rcount_next = 1'b0;
                                    if (kind == msp_pkg::NIB_CTRL && c0 == msp_pkg::CC_NRPN_MSB) begin
                                        pph_next = c1;
                                        ppl_next = '0;
                                        pvh_next = '0;
                                    end else if (kind == msp_pkg::NIB_CTRL &&
                                                 c0 == msp_pkg::CC_NRPN_LSB) begin
                                        ppl_next = c1;
                                        pvh_next = '0;
                                    end else if (kind == msp_pkg::NIB_CTRL &&
                                                 c0 == msp_pkg::CC_DATA_MSB) begin
                                        pvh_next = c1;
                                    end else if (kind == msp_pkg::NIB_CTRL &&
                                                 c0 == msp_pkg::CC_DATA_LSB) begin
                                        res_next.event_res  = msp_pkg::EV_PARAM;
                                        res_next.param_high = pph_reg;
                                        res_next.param_low  = ppl_reg;
                                        res_next.value_high = pvh_reg;
                                        res_next.value_low  = c1;
                                    end else if (kind == msp_pkg::NIB_NOTE_OFF ||
                                                 kind == msp_pkg::NIB_NOTE_ON ||
                                                 kind == msp_pkg::NIB_CTRL ||
                                                 kind == msp_pkg::NIB_BEND) begin
                                        res_next.event_res   = msp_pkg::EV_CHANNEL;
                                        res_next.status_out  = rstat_reg;
                                        res_next.first_data  = c0;
                                        res_next.second_data = c1;
                                    end else if (kind == msp_pkg::NIB_CHAN_AT) begin
                                        res_next.event_res  = msp_pkg::EV_CHANNEL;
                                        res_next.status_out = rstat_reg;
                                        res_next.first_data = c0;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NONE;
            rstat_reg    <= 8'd0;
            need_two_reg <= 1'b0;
            rcount_reg   <= 1'b0;
            d0_reg       <= 7'd0;
            d1_reg       <= 7'd0;
            pph_reg      <= 7'd0;
            ppl_reg      <= 7'd0;
            pvh_reg      <= 7'd0;
            valid_reg    <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            rstat_reg    <= rstat_next;
            need_two_reg <= need_two_next;
            rcount_reg   <= rcount_next;
            d0_reg       <= d0_next;
            d1_reg       <= d1_next;
            pph_reg      <= pph_next;
            ppl_reg      <= ppl_next;
            pvh_reg      <= pvh_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

// File: src/midi_stream_parser.sv
// MIDI byte stream parser with running status, NRPN assembly and
// parameter messages by system exclusive.
// The input channel (s_valid, s_ready, s_rx_byte) takes one received byte
// per item. The result channel (m_valid, m_ready, m_*) gives exactly one
// result item for every input item, in order; m_event_res is zero when the
// byte completes nothing.
// The configuration port writes the three sysex ID bytes and the auto store
// flag at any edge where cfg_wr_en is high; write it only while idle.
// An accepted item is held in the queue, then its result in the output
// register. The block takes one item per cycle as long as m_ready stays
// high; the single state update in the back end sets that rate.
// A two-entry queue sits between the byte classifier and the back end, and
// the result sits in an output register, so a stalled receiver lets two
// more items in before s_ready falls.
// A synchronous reset clears the running status, the sysex phase, the
// pending parameter parts, the queue, the output valid and the
// configuration registers.
module midi_stream_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_status_out,
    output logic [6:0] m_first_data,
    output logic [6:0] m_second_data,
    output logic [6:0] m_param_high,
    output logic [6:0] m_param_low,
    output logic [6:0] m_value_high,
    output logic [6:0] m_value_low,
    output logic       m_save_patch,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_wdata
);

    msp_pkg::cfg_t    cfg_reg;
    msp_pkg::cfg_t    cfg_next;
    msp_pkg::entry_t  front_entry;
    msp_pkg::entry_t  head_entry;
    msp_pkg::result_t res;
    logic             q_full;
    logic             head_valid;
    logic             pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                msp_pkg::REG_ID_FIRST:   cfg_next.id_first   = cfg_wdata;
                msp_pkg::REG_ID_SECOND:  cfg_next.id_second  = cfg_wdata;
                msp_pkg::REG_ID_THIRD:   cfg_next.id_third   = cfg_wdata;
                msp_pkg::REG_AUTO_STORE: cfg_next.auto_store = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;

    msp_front u_front (
        .rx_byte (s_rx_byte),
        .entry   (front_entry)
    );

    msp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    msp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res        (res)
    );

    assign m_event_res   = res.event_res;
    assign m_status_out  = res.status_out;
    assign m_first_data  = res.first_data;
    assign m_second_data = res.second_data;
    assign m_param_high  = res.param_high;
    assign m_param_low   = res.param_low;
    assign m_value_high  = res.value_high;
    assign m_value_low   = res.value_low;
    assign m_save_patch  = res.save_patch;

endmodule

// File: tb/sv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SX_NONE,
        SX_IGNORE,
        SX_ID_FIRST,
        SX_ID_SECOND,
        SX_ID_THIRD,
        SX_PARAM_HIGH,
        SX_PARAM_LOW,
        SX_VALUE_HIGH,
        SX_VALUE_LOW
    } sx_phase_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_res;
    logic [7:0] m_status_out;
    logic [6:0] m_first_data;
    logic [6:0] m_second_data;
    logic [6:0] m_param_high;
    logic [6:0] m_param_low;
    logic [6:0] m_value_high;
    logic [6:0] m_value_low;
    logic       m_save_patch;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [6:0] cfg_wdata = '0;

    midi_stream_parser uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_status_out  (m_status_out),
        .m_first_data  (m_first_data),
        .m_second_data (m_second_data),
        .m_param_high  (m_param_high),
        .m_param_low   (m_param_low),
        .m_value_high  (m_value_high),
        .m_value_low   (m_value_low),
        .m_save_patch  (m_save_patch),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Shadow of the configuration registers and of the parser state.
    logic [6:0] id_reg [3] = '{default: '0};
    logic       store_reg = 1'b0;
    logic [7:0] run_status = '0;
    logic [1:0] need_cnt = '0;
    logic [1:0] got_cnt = '0;
    logic [6:0] held_data [2] = '{default: '0};
    sx_phase_t  sx_phase = SX_NONE;
    logic [6:0] nrpn_param_high = '0;
    logic [6:0] nrpn_param_low = '0;
    logic [6:0] nrpn_value_high = '0;

    logic [7:0]       pending_bytes [$];
    msp_pkg::result_t expected_results [$];
    msp_pkg::result_t want_res;

    int failures = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int event_tally [8] = '{default: 0};
    bit calm = 1'b0;

    int send_gap = 0;
    int send_cycle = 0;
    bit send_bursty = 1'b1;
    int recv_stall = 0;
    int recv_hold = 0;
    int recv_cycle = 0;
    bit recv_bursty = 1'b1;

    logic [3:0] gen_kind = msp_pkg::NIB_NOTE_ON;

    function automatic msp_pkg::result_t parse_byte(input logic [7:0] b);
        msp_pkg::result_t r;
        logic [3:0] kind;
        logic [6:0] d0;
        logic [6:0] d1;
        r = '0;
        if (b[7:4] == msp_pkg::NIB_SYSTEM) begin
            if (b == msp_pkg::BYTE_CLOCK || b == msp_pkg::BYTE_START ||
                b == msp_pkg::BYTE_CONTINUE || b == msp_pkg::BYTE_STOP) begin
                r.event_res = msp_pkg::EV_REALTIME;
                r.status_out = b;
            end else if (b == msp_pkg::BYTE_SX_START) begin
                sx_phase = SX_ID_FIRST;
            end else if (b == msp_pkg::BYTE_SX_END) begin
                if (sx_phase == SX_PARAM_HIGH) begin
                    r.event_res = msp_pkg::EV_APPLIED;
                    r.save_patch = store_reg;
                end else if (sx_phase >= SX_ID_FIRST && sx_phase <= SX_VALUE_LOW) begin
                    r.event_res = msp_pkg::EV_ERROR;
                end
                sx_phase = SX_NONE;
            end
        end else if (b[7]) begin
            kind = b[7:4];
            sx_phase = SX_NONE;
            got_cnt = '0;
            run_status = b;
            need_cnt = (kind == msp_pkg::NIB_POLY_AT || kind == msp_pkg::NIB_PROGRAM ||
                        kind == msp_pkg::NIB_CHAN_AT) ? 2'd1 : 2'd2;
        end else begin
            case (sx_phase)
                SX_ID_FIRST: begin
                    sx_phase = (b[6:0] == id_reg[0]) ? SX_ID_SECOND : SX_IGNORE;
                end
                SX_ID_SECOND: begin
                    sx_phase = (b[6:0] == id_reg[1]) ? SX_ID_THIRD : SX_IGNORE;
                end
                SX_ID_THIRD: begin
                    sx_phase = (b[6:0] == id_reg[2]) ? SX_PARAM_HIGH : SX_IGNORE;
                end
                SX_PARAM_HIGH: begin
                    nrpn_param_high = b[6:0];
                    sx_phase = SX_PARAM_LOW;
                end
                SX_PARAM_LOW: begin
                    nrpn_param_low = b[6:0];
                    sx_phase = SX_VALUE_HIGH;
                end
                SX_VALUE_HIGH: begin
                    nrpn_value_high = b[6:0];
                    sx_phase = SX_VALUE_LOW;
                end
                SX_VALUE_LOW: begin
                    r.event_res = msp_pkg::EV_PARAM;
                    r.param_high = nrpn_param_high;
                    r.param_low = nrpn_param_low;
                    r.value_high = nrpn_value_high;
                    r.value_low = b[6:0];
                    sx_phase = SX_PARAM_HIGH;
                end
                SX_NONE: begin
                    if (run_status != 8'd0) begin
                        held_data[got_cnt[0]] = b[6:0];
                        got_cnt = got_cnt + 2'd1;
                        if (got_cnt >= need_cnt) begin
                            got_cnt = '0;
                            kind = run_status[7:4];
                            d0 = held_data[0];
                            d1 = held_data[1];
                            if (kind == msp_pkg::NIB_CTRL && d0 == msp_pkg::CC_NRPN_MSB) begin
                                nrpn_param_high = d1;
                                nrpn_param_low = '0;
                                nrpn_value_high = '0;
                            end else if (kind == msp_pkg::NIB_CTRL &&
                                         d0 == msp_pkg::CC_NRPN_LSB) begin
                                nrpn_param_low = d1;
                                nrpn_value_high = '0;
                            end else if (kind == msp_pkg::NIB_CTRL &&
                                         d0 == msp_pkg::CC_DATA_MSB) begin
                                nrpn_value_high = d1;
                            end else if (kind == msp_pkg::NIB_CTRL &&
                                         d0 == msp_pkg::CC_DATA_LSB) begin
                                r.event_res = msp_pkg::EV_PARAM;
                                r.param_high = nrpn_param_high;
                                r.param_low = nrpn_param_low;
                                r.value_high = nrpn_value_high;
                                r.value_low = d1;
                            end else if (kind == msp_pkg::NIB_NOTE_OFF ||
                                         kind == msp_pkg::NIB_NOTE_ON ||
                                         kind == msp_pkg::NIB_CTRL ||
                                         kind == msp_pkg::NIB_BEND) begin
                                r.event_res = msp_pkg::EV_CHANNEL;
                                r.status_out = run_status;
                                r.first_data = d0;
                                r.second_data = d1;
                            end else if (kind == msp_pkg::NIB_CHAN_AT) begin
                                r.event_res = msp_pkg::EV_CHANNEL;
                                r.status_out = run_status;
                                r.first_data = d0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: mismatch in %s, expected %0h, actual %0h",
                     $time, name, want, got);
            failures++;
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(parse_byte(s_rx_byte));
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_rx_byte <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && send_bursty && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 9);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            send_cycle++;
            if (send_cycle % 89 == 0) begin
                send_bursty = ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result item with nothing expected, event %0d",
                             $time, m_event_res);
                    failures++;
                end else begin
                    want_res = expected_results.pop_front();
                    check_field("event_res", 8'(want_res.event_res), 8'(m_event_res));
                    check_field("status_out", want_res.status_out, m_status_out);
                    check_field("first_data", 8'(want_res.first_data), 8'(m_first_data));
                    check_field("second_data", 8'(want_res.second_data),
                                8'(m_second_data));
                    check_field("param_high", 8'(want_res.param_high), 8'(m_param_high));
                    check_field("param_low", 8'(want_res.param_low), 8'(m_param_low));
                    check_field("value_high", 8'(want_res.value_high), 8'(m_value_high));
                    check_field("value_low", 8'(want_res.value_low), 8'(m_value_low));
                    check_field("save_patch", 8'(want_res.save_patch), 8'(m_save_patch));
                end
                results_seen++;
                event_tally[m_event_res]++;
                if (results_seen == 300) begin
                    recv_hold = 250;
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && recv_bursty && $urandom_range(0, 4) == 0) begin
                    recv_stall = $urandom_range(1, 9);
                end
            end
            recv_cycle++;
            if (recv_cycle % 71 == 0) begin
                recv_bursty = ($urandom_range(0, 2) != 0);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h7F;
            default: return {1'b0, 7'($urandom_range(0, 127))};
        endcase
    endfunction

    function automatic logic [7:0] pick_realtime();
        case ($urandom_range(0, 3))
            0: return msp_pkg::BYTE_CLOCK;
            1: return msp_pkg::BYTE_START;
            2: return msp_pkg::BYTE_CONTINUE;
            default: return msp_pkg::BYTE_STOP;
        endcase
    endfunction

    task automatic add_status(input logic [3:0] kind);
        gen_kind = kind;
        push_byte({kind, 4'($urandom_range(0, 15))});
    endtask

    task automatic add_channel();
        logic [3:0] kind;
        kind = 4'($urandom_range(8, 14));
        if ($urandom_range(0, 3) != 0) begin
            add_status(kind);
        end
        if (gen_kind == msp_pkg::NIB_POLY_AT || gen_kind == msp_pkg::NIB_PROGRAM ||
            gen_kind == msp_pkg::NIB_CHAN_AT) begin
            push_byte(pick_data());
        end else begin
            if (gen_kind == msp_pkg::NIB_CTRL && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: push_byte({1'b0, msp_pkg::CC_NRPN_MSB});
                    1: push_byte({1'b0, msp_pkg::CC_NRPN_LSB});
                    2: push_byte({1'b0, msp_pkg::CC_DATA_MSB});
                    default: push_byte({1'b0, msp_pkg::CC_DATA_LSB});
                endcase
            end else begin
                push_byte(pick_data());
            end
            if ($urandom_range(0, 15) == 0) begin
                push_byte(pick_realtime());
            end
            push_byte(pick_data());
        end
    endtask

    task automatic add_nrpn();
        if (gen_kind != msp_pkg::NIB_CTRL || $urandom_range(0, 2) == 0) begin
            add_status(msp_pkg::NIB_CTRL);
        end
        if ($urandom_range(0, 4) != 0) begin
            push_byte({1'b0, msp_pkg::CC_NRPN_MSB});
            push_byte(pick_data());
        end
        if ($urandom_range(0, 4) != 0) begin
            push_byte({1'b0, msp_pkg::CC_NRPN_LSB});
            push_byte(pick_data());
        end
        if ($urandom_range(0, 4) != 0) begin
            push_byte({1'b0, msp_pkg::CC_DATA_MSB});
            push_byte(pick_data());
        end
        push_byte({1'b0, msp_pkg::CC_DATA_LSB});
        push_byte(pick_data());
    endtask

    task automatic add_sysex();
        int quads;
        push_byte(msp_pkg::BYTE_SX_START);
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_byte(pick_data());
            end else begin
                push_byte({1'b0, id_reg[k]});
            end
        end
        quads = $urandom_range(0, 3);
        for (int q = 0; q < quads; q++) begin
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(pick_realtime());
                end
                push_byte(pick_data());
            end
        end
        case ($urandom_range(0, 9))
            7: begin
                for (int k = $urandom_range(1, 3); k > 0; k--) begin
                    push_byte(pick_data());
                end
                push_byte(msp_pkg::BYTE_SX_END);
            end
            8: begin
                add_status(4'($urandom_range(8, 14)));
            end
            9: begin
                push_byte(msp_pkg::BYTE_SX_START);
                push_byte(msp_pkg::BYTE_SX_END);
            end
            default: begin
                push_byte(msp_pkg::BYTE_SX_END);
            end
        endcase
    endtask

    task automatic add_random(input int count);
        int stop_at;
        int pick;
        logic [7:0] ignored_sys [10] = '{8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5,
                                          8'hF6, 8'hF9, 8'hFD, 8'hFE, 8'hFF};
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_channel();
            end else if (pick < 55) begin
                add_nrpn();
            end else if (pick < 75) begin
                add_sysex();
            end else if (pick < 85) begin
                push_byte(pick_realtime());
            end else if (pick < 90) begin
                push_byte(ignored_sys[$urandom_range(0, 9)]);
            end else begin
                for (int k = $urandom_range(1, 3); k > 0; k--) begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            msp_pkg::REG_ID_FIRST: id_reg[0] = val;
            msp_pkg::REG_ID_SECOND: id_reg[1] = val;
            msp_pkg::REG_ID_THIRD: id_reg[2] = val;
            default: store_reg = val[0];
        endcase
    endtask

    task automatic set_config(input logic [6:0] id0, input logic [6:0] id1,
                              input logic [6:0] id2, input logic store_flag);
        wait_drained();
        repeat (4) @(posedge aclk);
        write_reg(msp_pkg::REG_ID_FIRST, id0);
        write_reg(msp_pkg::REG_ID_SECOND, id1);
        write_reg(msp_pkg::REG_ID_THIRD, id2);
        write_reg(msp_pkg::REG_AUTO_STORE, {6'd0, store_flag});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        static logic [7:0] opening [] = '{
            8'h45, msp_pkg::BYTE_CLOCK, msp_pkg::BYTE_START, msp_pkg::BYTE_CONTINUE,
            msp_pkg::BYTE_STOP, 8'hF1, 8'hFD, msp_pkg::BYTE_SX_END, 8'h90, 8'h00, 8'h7F,
            8'h7F, 8'h00, 8'hA3, 8'h10, 8'hC5, 8'h7F, 8'hD2, 8'h7F, 8'hEF, 8'h00, 8'h7F
        };
        static logic [7:0] nrpn_and_sysex [] = '{
            8'hB0, 8'h63, 8'h01, 8'h62, 8'h02, 8'h06, 8'h03, 8'h26, 8'h04,
            msp_pkg::BYTE_SX_START, 8'h7F, 8'h7F, 8'h7F, 8'h11, 8'h22, 8'h33, 8'h44,
            msp_pkg::BYTE_CLOCK, msp_pkg::BYTE_SX_END
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening[k]) push_byte(opening[k]);
        add_random(150);

        set_config(7'h7F, 7'h7F, 7'h7F, 1'b1);
        foreach (nrpn_and_sysex[k]) push_byte(nrpn_and_sysex[k]);
        add_random(200);

        set_config(7'h00, 7'h00, 7'h00, 1'b0);
        add_random(200);

        set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        add_random(200);

        set_config(7'h41, 7'h00, 7'h7F, 1'b1);
        add_random(200);

        set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        calm = 1'b1;
        add_random(150);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes under six register settings, %0d results checked.",
                 bytes_taken, results_seen);
        $display("Events: %0d channel, %0d parameter, %0d applied, %0d error, %0d realtime.",
                 event_tally[msp_pkg::EV_CHANNEL], event_tally[msp_pkg::EV_PARAM],
                 event_tally[msp_pkg::EV_APPLIED], event_tally[msp_pkg::EV_ERROR],
                 event_tally[msp_pkg::EV_REALTIME]);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
